// ===== rtl/core/bthalloc_pkg.sv =====
// Shared types and constants of the boundary-tag heap allocator.
`default_nettype none
package bthalloc_pkg;

  localparam logic [31:0] NilAddr    = 32'h0001_FFFF;
  localparam logic [31:0] InUse      = 32'h0000_0001;
  localparam logic [31:0] HdrBytes   = 32'd8;
  localparam logic [31:0] SplitMin   = 32'd16;

  typedef enum logic [0:0] {
    CFG_REGION_BEGIN = 1'b0,
    CFG_REGION_END   = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    RET_ALLOC,
    RET_FNEXT,
    RET_FPREV
  } ret_e;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE,
    ST_FMT_CHK, ST_FMT_W1, ST_FMT_W2, ST_FMT_W3, ST_FMT_W4, ST_FMT_W5,
    ST_A_CHK, ST_A_FAIL, ST_A_SZ, ST_A_NX,
    ST_RM0, ST_RM1, ST_RM2, ST_RM3, ST_RM4,
    ST_AS0, ST_AS1, ST_AS2, ST_AS3, ST_AS4, ST_AN1, ST_AN2,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F_RDSZ, ST_F_ADD, ST_F5, ST_F6, ST_F8, ST_F9,
    ST_I0, ST_I1, ST_I2, ST_I3, ST_I4, ST_I5, ST_I6, ST_I7, ST_I8,
    ST_DONE
  } state_e;

  typedef enum logic [5:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_FMT_LATCH, OP_HEAD_NIL,
    OP_FMT_W0, OP_FMT_W1, OP_FMT_W2, OP_FMT_W3, OP_FMT_W4, OP_FMT_W5,
    OP_RES_FAIL, OP_RD_CUR4, OP_FIT, OP_RD_CUR8, OP_NXT,
    OP_RD_RM8, OP_RD_RM12, OP_RM_PV, OP_HEAD_NX, OP_WR_PV8_NX, OP_WR_NX12_PV,
    OP_RES_OK, OP_WR_CUR4_NEED, OP_WR_CURN_NEED, OP_WR_TAIL4, OP_WR_TAILEND,
    OP_WR_CUR4_SZ, OP_WR_CURS_SZ,
    OP_RD_SELF4, OP_TOTAL, OP_RD_NXT4, OP_SET_RM_NXT, OP_RD_RM4, OP_ADD_TOTAL,
    OP_RD_SELF, OP_SET_RM_PRV, OP_WR_SELF4, OP_WR_SELFT,
    OP_RD_INS4, OP_INS_INIT, OP_INS_STEP, OP_WR_INS12, OP_WR_INS8,
    OP_HEAD_INS, OP_WR_PV8_INS, OP_WR_CUR12_INS, OP_PUSH
  } dp_op_e;

  typedef struct packed {
    logic cur_nil;
    logic cnt_max;
    logic pv_nil;
    logic nx_nil;
    logic rd_free;
    logic fits;
    logic less;
    logic split;
    logic fmt_empty;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/bthalloc_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module bthalloc_ram #(
  parameter int Width = 32,
  parameter int Depth = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== rtl/core/bthalloc_dp.sv =====
// Datapath of the heap allocator: heap memory, pointer registers, result register.
`default_nettype none
module bthalloc_dp #(
  parameter int HeapAddrBits = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bthalloc_pkg::dp_op_e         op_i,
  output bthalloc_pkg::dp_status_t          status_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_addr_i,
  input  wire logic [16:0]                  cfg_wdata_i,
  input  wire logic [16:0]                  request_bytes_i,
  input  wire logic [15:0]                  release_addr_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              granted_o,
  output logic      [15:0]                  payload_addr_o
);
  import bthalloc_pkg::*;

  localparam int WordW     = HeapAddrBits - 2;
  localparam int CntW      = HeapAddrBits - 3;
  localparam int WalkLimit = (1 << (HeapAddrBits - 4)) + 1;

  logic [16:0]      rb_q, re_q;
  logic [WordW-1:0] clr_q;
  logic             out_valid_q, granted_q;
  logic [15:0]      paddr_q;
  logic             res_ok_q;
  logic [15:0]      res_addr_q;
  logic [31:0]      head_q, cur_q, pv_q, nx_q, sz_q, need_q, self_q, total_q;
  logic [31:0]      ins_q, ins_s_q, rm_q, fh_q, fs_q;
  logic             fempty_q;
  logic [CntW-1:0]  cnt_q;

  logic             mem_we;
  logic [31:0]      mem_byte;
  logic [WordW-1:0] mem_word;
  logic [31:0]      mem_wdata, rdata, rsize;

  logic [16:0]      req_c;
  logic [31:0]      fb_c, fe_c;

  assign rsize = rdata & ~InUse;
  assign req_c = (request_bytes_i <= 17'd8) ? 17'd8 : request_bytes_i;
  assign fb_c  = ({15'd0, rb_q} + 32'd15) & ~32'd7;
  assign fe_c  = ({15'd0, re_q} - HdrBytes) & ~32'd7;

  // Memory access for this op.
  always_comb begin
    mem_we    = 1'b0;
    mem_byte  = '0;
    mem_wdata = '0;
    case (op_i)
      OP_FMT_W0:       begin mem_we = 1'b1; mem_byte = fh_q + 32'd4; mem_wdata = fs_q; end
      OP_FMT_W1:       begin mem_we = 1'b1; mem_byte = fh_q + fs_q; mem_wdata = fs_q; end
      OP_FMT_W2:       begin mem_we = 1'b1; mem_byte = fh_q; mem_wdata = InUse; end
      OP_FMT_W3:       begin mem_we = 1'b1; mem_byte = fh_q + fs_q + 32'd4; mem_wdata = InUse; end
      OP_FMT_W4:       begin mem_we = 1'b1; mem_byte = fh_q + 32'd12; mem_wdata = NilAddr; end
      OP_FMT_W5:       begin mem_we = 1'b1; mem_byte = fh_q + 32'd8; mem_wdata = NilAddr; end
      OP_RD_CUR4:      mem_byte = cur_q + 32'd4;
      OP_RD_CUR8:      mem_byte = cur_q + 32'd8;
      OP_INS_STEP:     mem_byte = cur_q + 32'd8;
      OP_RD_RM8:       mem_byte = rm_q + 32'd8;
      OP_RD_RM12:      mem_byte = rm_q + 32'd12;
      OP_RD_RM4:       mem_byte = rm_q + 32'd4;
      OP_WR_PV8_NX:    begin mem_we = 1'b1; mem_byte = pv_q + 32'd8; mem_wdata = nx_q; end
      OP_WR_NX12_PV:   begin mem_we = 1'b1; mem_byte = nx_q + 32'd12; mem_wdata = pv_q; end
      OP_WR_CUR4_NEED: begin mem_we = 1'b1; mem_byte = cur_q + 32'd4; mem_wdata = need_q | InUse; end
      OP_WR_CURN_NEED: begin mem_we = 1'b1; mem_byte = cur_q + need_q; mem_wdata = need_q | InUse; end
      OP_WR_TAIL4:     begin
        mem_we = 1'b1; mem_byte = cur_q + need_q + 32'd4; mem_wdata = sz_q - need_q;
      end
      OP_WR_TAILEND:   begin mem_we = 1'b1; mem_byte = cur_q + sz_q; mem_wdata = sz_q - need_q; end
      OP_WR_CUR4_SZ:   begin mem_we = 1'b1; mem_byte = cur_q + 32'd4; mem_wdata = sz_q | InUse; end
      OP_WR_CURS_SZ:   begin mem_we = 1'b1; mem_byte = cur_q + sz_q; mem_wdata = sz_q | InUse; end
      OP_RD_SELF4:     mem_byte = self_q + 32'd4;
      OP_RD_NXT4:      mem_byte = self_q + total_q + 32'd4;
      OP_RD_SELF:      mem_byte = self_q;
      OP_WR_SELF4:     begin mem_we = 1'b1; mem_byte = self_q + 32'd4; mem_wdata = total_q; end
      OP_WR_SELFT:     begin mem_we = 1'b1; mem_byte = self_q + total_q; mem_wdata = total_q; end
      OP_RD_INS4:      mem_byte = ins_q + 32'd4;
      OP_WR_INS12:     begin mem_we = 1'b1; mem_byte = ins_q + 32'd12; mem_wdata = pv_q; end
      OP_WR_INS8:      begin mem_we = 1'b1; mem_byte = ins_q + 32'd8; mem_wdata = cur_q; end
      OP_WR_PV8_INS:   begin mem_we = 1'b1; mem_byte = pv_q + 32'd8; mem_wdata = ins_q; end
      OP_WR_CUR12_INS: begin mem_we = 1'b1; mem_byte = cur_q + 32'd12; mem_wdata = ins_q; end
      OP_CLEAR:        mem_we = 1'b1;
      default:         mem_we = 1'b0;
    endcase
  end

  assign mem_word = (op_i == OP_CLEAR) ? clr_q : mem_byte[HeapAddrBits-1:2];

  bthalloc_ram #(
    .Width(32),
    .Depth(1 << WordW)
  ) u_heap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_word),
    .wdata_i (mem_wdata),
    .rdata_o (rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_q        <= '0;
      re_q        <= 17'h1_0000;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_addr_i) == CFG_REGION_BEGIN) begin
          rb_q <= cfg_wdata_i;
        end else begin
          re_q <= cfg_wdata_i;
        end
      end
      if (op_i == OP_CLEAR) begin
        clr_q <= clr_q + WordW'(1);
      end
      if (op_i == OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pointer and payload registers.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_ACCEPT: begin
        need_q <= ({15'd0, req_c} + 32'd15) & ~32'd7;
        cur_q  <= head_q;
        cnt_q  <= '0;
        self_q <= {16'd0, release_addr_i} - HdrBytes;
      end
      OP_FMT_LATCH: begin
        fh_q     <= fb_c - HdrBytes;
        fs_q     <= fe_c - fb_c;
        fempty_q <= (re_q < 17'd8) || (fe_c <= fb_c);
      end
      OP_HEAD_NIL:   head_q <= NilAddr;
      OP_FMT_W5:     head_q <= fh_q;
      OP_RES_FAIL:   begin res_ok_q <= 1'b0; res_addr_q <= '0; end
      OP_FIT:        begin sz_q <= rsize; rm_q <= cur_q; end
      OP_NXT:        begin cur_q <= rdata; cnt_q <= cnt_q + CntW'(1); end
      OP_RD_RM12:    nx_q <= rdata;
      OP_RM_PV:      pv_q <= rdata;
      OP_HEAD_NX:    head_q <= nx_q;
      OP_RES_OK:     begin res_ok_q <= 1'b1; res_addr_q <= cur_q[15:0] + 16'd8; end
      OP_WR_TAILEND: ins_q <= cur_q + need_q;
      OP_TOTAL:      total_q <= rsize;
      OP_SET_RM_NXT: rm_q <= self_q + total_q;
      OP_ADD_TOTAL:  total_q <= total_q + rsize;
      OP_SET_RM_PRV: begin rm_q <= self_q - rsize; self_q <= self_q - rsize; end
      OP_WR_SELFT:   begin ins_q <= self_q; res_ok_q <= 1'b1; res_addr_q <= '0; end
      OP_INS_INIT: begin
        ins_s_q <= rsize;
        pv_q    <= NilAddr;
        cur_q   <= head_q;
        cnt_q   <= '0;
      end
      OP_INS_STEP:   pv_q <= cur_q;
      OP_HEAD_INS:   head_q <= ins_q;
      OP_PUSH:       begin granted_q <= res_ok_q; paddr_q <= res_addr_q; end
      default:       ;
    endcase
  end

  always_comb begin
    status_o.cur_nil   = (cur_q == NilAddr);
    status_o.cnt_max   = (cnt_q == CntW'(WalkLimit));
    status_o.pv_nil    = (pv_q == NilAddr);
    status_o.nx_nil    = (nx_q == NilAddr);
    status_o.rd_free   = ~rdata[0];
    status_o.fits      = (rsize >= need_q);
    status_o.less      = (rsize < ins_s_q);
    status_o.split     = ((sz_q - need_q) >= SplitMin);
    status_o.fmt_empty = fempty_q;
    status_o.clr_last  = &clr_q;
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign payload_addr_o = paddr_q;
endmodule
`default_nettype wire

// ===== rtl/core/bthalloc_ctrl.sv =====
// Controller state machine of the heap allocator.
`default_nettype none
module bthalloc_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     func_i,
  input  wire logic                     cfg_we_i,
  input  wire bthalloc_pkg::dp_status_t status_i,
  output bthalloc_pkg::dp_op_e          op_o
);
  import bthalloc_pkg::*;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  logic   pend_q, pend_d;
  logic   idle_rdy;

  assign idle_rdy   = (state_q == ST_IDLE) && !pend_q;
  assign in_stall_o = !idle_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ret_q   <= RET_ALLOC;
      pend_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pend_q  <= pend_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    pend_d  = pend_q;
    if ((state_q == ST_IDLE) && pend_q) begin
      pend_d = 1'b0;
    end
    if (cfg_we_i) begin
      pend_d = 1'b1;
    end
    case (state_q)
      ST_CLEAR:   if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (pend_q) begin
          state_d = ST_FMT_CHK;
        end else if (in_valid_i) begin
          state_d = (func_e'(func_i) == FUNC_FREE) ? ST_F0 : ST_A_CHK;
        end
      end
      ST_FMT_CHK: state_d = status_i.fmt_empty ? ST_IDLE : ST_FMT_W1;
      ST_FMT_W1:  state_d = ST_FMT_W2;
      ST_FMT_W2:  state_d = ST_FMT_W3;
      ST_FMT_W3:  state_d = ST_FMT_W4;
      ST_FMT_W4:  state_d = ST_FMT_W5;
      ST_FMT_W5:  state_d = ST_IDLE;
      ST_A_CHK:   state_d = (status_i.cur_nil || status_i.cnt_max) ? ST_A_FAIL : ST_A_SZ;
      ST_A_FAIL:  state_d = ST_DONE;
      ST_A_SZ: begin
        if (status_i.fits) begin
          state_d = ST_RM0;
          ret_d   = RET_ALLOC;
        end else begin
          state_d = ST_A_NX;
        end
      end
      ST_A_NX:    state_d = ST_A_CHK;
      ST_RM0:     state_d = ST_RM1;
      ST_RM1:     state_d = ST_RM2;
      ST_RM2:     state_d = ST_RM3;
      ST_RM3:     state_d = ST_RM4;
      ST_RM4:     state_d = (ret_q == RET_ALLOC) ? ST_AS0 : ST_F_RDSZ;
      ST_AS0:     state_d = status_i.split ? ST_AS1 : ST_AN1;
      ST_AS1:     state_d = ST_AS2;
      ST_AS2:     state_d = ST_AS3;
      ST_AS3:     state_d = ST_AS4;
      ST_AS4:     state_d = ST_I0;
      ST_AN1:     state_d = ST_AN2;
      ST_AN2:     state_d = ST_DONE;
      ST_F0:      state_d = ST_F1;
      ST_F1:      state_d = ST_F2;
      ST_F2:      state_d = ST_F3;
      ST_F3: begin
        if (status_i.rd_free) begin
          state_d = ST_RM0;
          ret_d   = RET_FNEXT;
        end else begin
          state_d = ST_F5;
        end
      end
      ST_F_RDSZ:  state_d = ST_F_ADD;
      ST_F_ADD:   state_d = (ret_q == RET_FNEXT) ? ST_F5 : ST_F8;
      ST_F5:      state_d = ST_F6;
      ST_F6: begin
        if (status_i.rd_free) begin
          state_d = ST_RM0;
          ret_d   = RET_FPREV;
        end else begin
          state_d = ST_F8;
        end
      end
      ST_F8:      state_d = ST_F9;
      ST_F9:      state_d = ST_I0;
      ST_I0:      state_d = ST_I1;
      ST_I1:      state_d = ST_I2;
      ST_I2:      state_d = (status_i.cur_nil || status_i.cnt_max) ? ST_I5 : ST_I3;
      ST_I3:      state_d = status_i.less ? ST_I4 : ST_I5;
      ST_I4:      state_d = ST_I2;
      ST_I5:      state_d = ST_I6;
      ST_I6:      state_d = ST_I7;
      ST_I7:      state_d = ST_I8;
      ST_I8:      state_d = ST_DONE;
      ST_DONE:    if (status_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath command.
  always_comb begin
    op_o = OP_NONE;
    case (state_q)
      ST_CLEAR: op_o = OP_CLEAR;
      ST_IDLE: begin
        if (pend_q) begin
          op_o = OP_FMT_LATCH;
        end else if (in_valid_i) begin
          op_o = OP_ACCEPT;
        end
      end
      ST_FMT_CHK: op_o = status_i.fmt_empty ? OP_HEAD_NIL : OP_FMT_W0;
      ST_FMT_W1:  op_o = OP_FMT_W1;
      ST_FMT_W2:  op_o = OP_FMT_W2;
      ST_FMT_W3:  op_o = OP_FMT_W3;
      ST_FMT_W4:  op_o = OP_FMT_W4;
      ST_FMT_W5:  op_o = OP_FMT_W5;
      ST_A_CHK:   op_o = (status_i.cur_nil || status_i.cnt_max) ? OP_NONE : OP_RD_CUR4;
      ST_A_FAIL:  op_o = OP_RES_FAIL;
      ST_A_SZ:    op_o = status_i.fits ? OP_FIT : OP_RD_CUR8;
      ST_A_NX:    op_o = OP_NXT;
      ST_RM0:     op_o = OP_RD_RM8;
      ST_RM1:     op_o = OP_RD_RM12;
      ST_RM2:     op_o = OP_RM_PV;
      ST_RM3:     op_o = status_i.pv_nil ? OP_HEAD_NX : OP_WR_PV8_NX;
      ST_RM4:     op_o = status_i.nx_nil ? OP_NONE : OP_WR_NX12_PV;
      ST_AS0:     op_o = OP_RES_OK;
      ST_AS1:     op_o = OP_WR_CUR4_NEED;
      ST_AS2:     op_o = OP_WR_CURN_NEED;
      ST_AS3:     op_o = OP_WR_TAIL4;
      ST_AS4:     op_o = OP_WR_TAILEND;
      ST_AN1:     op_o = OP_WR_CUR4_SZ;
      ST_AN2:     op_o = OP_WR_CURS_SZ;
      ST_F0:      op_o = OP_RD_SELF4;
      ST_F1:      op_o = OP_TOTAL;
      ST_F2:      op_o = OP_RD_NXT4;
      ST_F3:      op_o = status_i.rd_free ? OP_SET_RM_NXT : OP_NONE;
      ST_F_RDSZ:  op_o = OP_RD_RM4;
      ST_F_ADD:   op_o = OP_ADD_TOTAL;
      ST_F5:      op_o = OP_RD_SELF;
      ST_F6:      op_o = status_i.rd_free ? OP_SET_RM_PRV : OP_NONE;
      ST_F8:      op_o = OP_WR_SELF4;
      ST_F9:      op_o = OP_WR_SELFT;
      ST_I0:      op_o = OP_RD_INS4;
      ST_I1:      op_o = OP_INS_INIT;
      ST_I2:      op_o = (status_i.cur_nil || status_i.cnt_max) ? OP_NONE : OP_RD_CUR4;
      ST_I3:      op_o = status_i.less ? OP_INS_STEP : OP_NONE;
      ST_I4:      op_o = OP_NXT;
      ST_I5:      op_o = OP_WR_INS12;
      ST_I6:      op_o = OP_WR_INS8;
      ST_I7:      op_o = status_i.pv_nil ? OP_HEAD_INS : OP_WR_PV8_INS;
      ST_I8:      op_o = status_i.cur_nil ? OP_NONE : OP_WR_CUR12_INS;
      ST_DONE:    op_o = status_i.out_free ? OP_PUSH : OP_NONE;
      default:    op_o = OP_NONE;
    endcase
  end

  a_cfg_sets_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> pend_q)
    else $error("config write did not schedule a reformat");

  a_pend_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> in_stall_o)
    else $error("input taken while reformat pending");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && status_i.out_free) |=> (state_q == ST_IDLE))
    else $error("result delivered but controller not idle");

  a_fmt_before_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("input taken during heap clear");
endmodule
`default_nettype wire

// ===== rtl/core/boundary_tag_heap_allocator.sv =====
// Top level of the boundary-tag best-fit heap allocator.
`default_nettype none
// Boundary-tag best-fit heap allocator. The heap lives in an internal single-port
// word memory of 2^(HeapAddrBits-2) 32-bit words; every operation goes through that one
// port, one access per cycle. One transaction is worked on at a time. An allocate
// walks the free list to the first chunk that fits, unlinks it and, when the remainder
// is large enough, splits it off and reinserts it; a failed allocate ends at the end of
// the list or at the walk limit. A free reads the chunk's size, merges it with each
// free neighbor (up to two: the next and the previous chunk) and reinserts the result.
// A held output keeps a finished transaction waiting until the output register is free.
// The free list is kept sorted by size, so the first fit is the best fit. After reset
// the block clears the whole heap memory, all 2^(HeapAddrBits-2) words (16384 at the
// default), and then formats the region; during that time in_stall_o stays high, but
// configuration writes are taken. Each configuration write reformats the region as one
// free chunk, or as an empty free list if it has no room, before the next transaction
// is accepted. Requests larger than any free chunk return granted_o = 0. A finished
// result waits in an output register, so the next transaction is accepted while it is
// still held.
module boundary_tag_heap_allocator #(
  parameter int HeapAddrBits = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [16:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [16:0] request_bytes_i,
  input  wire logic [15:0] release_addr_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             granted_o,
  output logic      [15:0] payload_addr_o
);
  import bthalloc_pkg::*;

  dp_op_e     op;
  dp_status_t status;

  bthalloc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .cfg_we_i   (cfg_we_i),
    .status_i   (status),
    .op_o       (op)
  );

  bthalloc_dp #(
    .HeapAddrBits(HeapAddrBits)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .request_bytes_i (request_bytes_i),
    .release_addr_i  (release_addr_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .granted_o       (granted_o),
    .payload_addr_o  (payload_addr_o)
  );
endmodule
`default_nettype wire
